// ===== rtl/core/ffha_pkg.sv =====
`default_nettype none

package ffha_pkg;

  // Default sizing of the heap store.
  localparam int unsigned HeapBytesDefault  = 4096;
  localparam int unsigned AlignBytesDefault = 4;

  // Header layout and list coding.
  localparam logic [31:0] HdrBytes = 32'd8;
  localparam logic [31:0] MarkKey  = 32'hA55A55AA;
  localparam logic [31:0] LinkEnd  = 32'h0001_FFFF;

  // Reset value of the size register.
  localparam logic [16:0] HeapSizeReset = 17'd4096;

  // Configuration register indexes.
  localparam logic CfgHeapBase = 1'b0;
  localparam logic CfgHeapSize = 1'b1;

  // Item operation codes.
  localparam logic OpAlloc   = 1'b0;
  localparam logic OpRelease = 1'b1;

  // Result status codes.
  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StIgnored = 2'd1;
  localparam logic [1:0] StNoFit   = 2'd2;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic [31:0] base;
    logic [16:0] eff_size;
    logic        init;
  } cfg_t;

  // An offset names a usable area header inside the heap.
  function automatic logic ok_area(input logic [31:0] off, input logic [16:0] eff);
    logic [31:0] eff32;
    eff32 = {15'b0, eff};
    return (off != LinkEnd) && (off[1:0] == 2'b00) && (eff32 >= HdrBytes) &&
           (off <= eff32 - HdrBytes);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ffha_ram.sv =====
`default_nettype none

module ffha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
`default_nettype none

module ffha_ctrl #(
  parameter int unsigned HeapBytes  = ffha_pkg::HeapBytesDefault,
  parameter int unsigned AlignBytes = ffha_pkg::AlignBytesDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire ffha_pkg::cfg_t                       cfg_i,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic                                 operation_i,
  input  wire logic [15:0]                          request_size_i,
  input  wire logic [31:0]                          release_address_i,
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic [31:0]                          granted_address_o,
  output      logic [1:0]                           status_o,
  output      logic                                 mem_we_o,
  output      logic [$clog2(HeapBytes/4)-1:0]       mem_waddr_o,
  output      logic [31:0]                          mem_wdata_o,
  output      logic [$clog2(HeapBytes/4)-1:0]       mem_raddr_o,
  input  wire logic [31:0]                          mem_rdata_i
);
  import ffha_pkg::*;

  localparam int unsigned StoreWords = HeapBytes / 4;
  localparam int unsigned Aw         = $clog2(StoreWords);
  localparam int unsigned WalkLimit  = StoreWords + 4;
  localparam int unsigned Nw         = $clog2(WalkLimit + 1);
  localparam logic [31:0] AlignM1    = 32'(AlignBytes - 1);
  localparam logic [31:0] SplitMin   = 32'(AlignBytes + 8);

  typedef enum logic [26:0] {
    S_CLEAR = 27'd1 << 0,
    S_INIT0 = 27'd1 << 1,
    S_INIT1 = 27'd1 << 2,
    S_IDLE  = 27'd1 << 3,
    S_A_CHK = 27'd1 << 4,
    S_A_RL  = 27'd1 << 5,
    S_A_EV  = 27'd1 << 6,
    S_A_NWL = 27'd1 << 7,
    S_A_NWS = 27'd1 << 8,
    S_A_PRV = 27'd1 << 9,
    S_A_CSZ = 27'd1 << 10,
    S_A_MRK = 27'd1 << 11,
    S_R_CHK = 27'd1 << 12,
    S_R_RS  = 27'd1 << 13,
    S_R_MK  = 27'd1 << 14,
    S_R_W1  = 27'd1 << 15,
    S_R_W1R = 27'd1 << 16,
    S_R_LH  = 27'd1 << 17,
    S_R_PL  = 27'd1 << 18,
    S_R_M   = 27'd1 << 19,
    S_R_MS  = 27'd1 << 20,
    S_R_MC  = 27'd1 << 21,
    S_R_MN  = 27'd1 << 22,
    S_R_MW1 = 27'd1 << 23,
    S_R_ML  = 27'd1 << 24,
    S_R_MW2 = 27'd1 << 25,
    S_DONE  = 27'd1 << 26
  } state_e;

  // Word index of a header word, wrapping over the store.
  function automatic logic [Aw-1:0] widx(input logic [31:0] off, input logic second);
    logic [31:0] w;
    w = (off >> 2) + {31'b0, second};
    return w[Aw-1:0];
  endfunction

  state_e         state_q, state_d;
  logic [Aw-1:0]  clr_q, clr_d;
  logic           init_pend_q, init_pend_d;
  logic [16:0]    head_q, head_d;
  logic [Nw-1:0]  n_q, n_d;
  logic           out_valid_q, out_valid_d;

  logic [31:0] need_q, need_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] prev_q, prev_d;
  logic [31:0] sz_q, sz_d;
  logic [31:0] nxt_q, nxt_d;
  logic [31:0] pl_q, pl_d;
  logic [31:0] h_q, h_d;
  logic [31:0] node_q, node_d;
  logic [31:0] sum_q, sum_d;
  logic        split_q, split_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [1:0]  res_st_q, res_st_d;
  logic [31:0] out_addr_q, out_addr_d;
  logic [1:0]  out_st_q, out_st_d;

  logic        accept;
  logic        walk_ok;
  logic [31:0] off_w;
  logic [32:0] top_w;

  assign in_stall_o        = (state_q != S_IDLE) || init_pend_q;
  assign accept            = in_valid_i && !in_stall_o;
  assign walk_ok           = n_q < Nw'(WalkLimit);
  assign off_w             = addr_q - cfg_i.base;
  assign top_w             = {1'b0, cfg_i.base} + {16'b0, cfg_i.eff_size};
  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_st_q;

  // Sequencer: one memory access per cycle, reads always after earlier writes.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    init_pend_d = init_pend_q || cfg_i.init;
    head_d      = head_q;
    n_d         = n_q;
    need_d      = need_q;
    addr_d      = addr_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    sz_d        = sz_q;
    nxt_d       = nxt_q;
    pl_d        = pl_q;
    h_d         = h_q;
    node_d      = node_q;
    sum_d       = sum_q;
    split_d     = split_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == Aw'(StoreWords - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_INIT0: begin
        if ({15'b0, cfg_i.eff_size} >= HdrBytes) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = widx(32'd0, 1'b0);
          mem_wdata_o = LinkEnd;
          state_d     = S_INIT1;
        end else begin
          head_d  = LinkEnd[16:0];
          state_d = S_IDLE;
        end
      end
      S_INIT1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(32'd0, 1'b1);
        mem_wdata_o = {15'b0, cfg_i.eff_size};
        head_d      = '0;
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        if (init_pend_q) begin
          init_pend_d = cfg_i.init;
          state_d     = S_INIT0;
        end else if (accept) begin
          need_d = ({16'b0, request_size_i} + HdrBytes + AlignM1) & ~AlignM1;
          addr_d = release_address_i;
          prev_d = LinkEnd;
          cur_d  = {15'b0, head_q};
          n_d    = '0;
          if (operation_i == OpAlloc) begin
            state_d = S_A_CHK;
          end else begin
            state_d = S_R_CHK;
          end
        end
      end
      // Allocation: visit free areas in order until one is large enough.
      S_A_CHK: begin
        if (walk_ok && ok_area(cur_q, cfg_i.eff_size)) begin
          mem_raddr_o = widx(cur_q, 1'b1);
          state_d     = S_A_RL;
        end else begin
          res_addr_d = '0;
          res_st_d   = StNoFit;
          state_d    = S_DONE;
        end
      end
      S_A_RL: begin
        mem_raddr_o = widx(cur_q, 1'b0);
        sz_d        = mem_rdata_i;
        state_d     = S_A_EV;
      end
      S_A_EV: begin
        if (sz_q >= need_q) begin
          nxt_d = mem_rdata_i;
          if (sz_q - need_q < SplitMin) begin
            pl_d    = mem_rdata_i;
            need_d  = sz_q;
            split_d = 1'b0;
            state_d = S_A_PRV;
          end else begin
            pl_d    = cur_q + need_q;
            split_d = 1'b1;
            state_d = S_A_NWL;
          end
        end else begin
          prev_d  = cur_q;
          cur_d   = mem_rdata_i;
          n_d     = n_q + 1'b1;
          state_d = S_A_CHK;
        end
      end
      S_A_NWL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(pl_q, 1'b0);
        mem_wdata_o = nxt_q;
        state_d     = S_A_NWS;
      end
      S_A_NWS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(pl_q, 1'b1);
        mem_wdata_o = sz_q - need_q;
        state_d     = S_A_PRV;
      end
      S_A_PRV: begin
        if (prev_q == LinkEnd) begin
          head_d = pl_q[16:0];
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = widx(prev_q, 1'b0);
          mem_wdata_o = pl_q;
        end
        state_d = split_q ? S_A_CSZ : S_A_MRK;
      end
      S_A_CSZ: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(cur_q, 1'b1);
        mem_wdata_o = need_q;
        state_d     = S_A_MRK;
      end
      S_A_MRK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(cur_q, 1'b0);
        mem_wdata_o = ~need_q ^ MarkKey;
        res_addr_d  = cfg_i.base + cur_q + HdrBytes;
        res_st_d    = StDone;
        state_d     = S_DONE;
      end
      // Release: check range and mark, then link in and merge.
      S_R_CHK: begin
        res_addr_d = '0;
        res_st_d   = StIgnored;
        h_d        = off_w - HdrBytes;
        if ((addr_q <= cfg_i.base) || ({1'b0, addr_q} >= top_w) ||
            (off_w < HdrBytes) || (off_w[1:0] != 2'b00)) begin
          state_d = S_DONE;
        end else begin
          mem_raddr_o = widx(off_w - HdrBytes, 1'b0);
          state_d     = S_R_RS;
        end
      end
      S_R_RS: begin
        mem_raddr_o = widx(h_q, 1'b1);
        nxt_d       = mem_rdata_i;
        state_d     = S_R_MK;
      end
      S_R_MK: begin
        if (nxt_q == (~mem_rdata_i ^ MarkKey)) begin
          prev_d  = LinkEnd;
          cur_d   = {15'b0, head_q};
          n_d     = '0;
          state_d = S_R_W1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_R_W1: begin
        if (walk_ok && ok_area(cur_q, cfg_i.eff_size) && (cur_q < h_q)) begin
          mem_raddr_o = widx(cur_q, 1'b0);
          state_d     = S_R_W1R;
        end else begin
          if (!ok_area(cur_q, cfg_i.eff_size)) begin
            cur_d = LinkEnd;
          end
          state_d = S_R_LH;
        end
      end
      S_R_W1R: begin
        prev_d  = cur_q;
        cur_d   = mem_rdata_i;
        n_d     = n_q + 1'b1;
        state_d = S_R_W1;
      end
      S_R_LH: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(h_q, 1'b0);
        mem_wdata_o = cur_q;
        state_d     = S_R_PL;
      end
      S_R_PL: begin
        if (prev_q == LinkEnd) begin
          head_d = h_q[16:0];
          node_d = h_q;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = widx(prev_q, 1'b0);
          mem_wdata_o = h_q;
          node_d      = prev_q;
        end
        n_d     = '0;
        state_d = S_R_M;
      end
      S_R_M: begin
        if (walk_ok && ok_area(node_q, cfg_i.eff_size) &&
            ((cur_q == LinkEnd) || (node_q < cur_q))) begin
          mem_raddr_o = widx(node_q, 1'b0);
          state_d     = S_R_MS;
        end else begin
          res_st_d = StDone;
          state_d  = S_DONE;
        end
      end
      S_R_MS: begin
        mem_raddr_o = widx(node_q, 1'b1);
        nxt_d       = mem_rdata_i;
        state_d     = S_R_MC;
      end
      S_R_MC: begin
        sz_d = mem_rdata_i;
        if (ok_area(nxt_q, cfg_i.eff_size) && (node_q + mem_rdata_i == nxt_q)) begin
          mem_raddr_o = widx(nxt_q, 1'b1);
          state_d     = S_R_MN;
        end else begin
          node_d  = nxt_q;
          n_d     = n_q + 1'b1;
          state_d = S_R_M;
        end
      end
      S_R_MN: begin
        sum_d   = sz_q + mem_rdata_i;
        state_d = S_R_MW1;
      end
      S_R_MW1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(node_q, 1'b1);
        mem_wdata_o = sum_q;
        state_d     = S_R_ML;
      end
      S_R_ML: begin
        mem_raddr_o = widx(nxt_q, 1'b0);
        state_d     = S_R_MW2;
      end
      S_R_MW2: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = widx(node_q, 1'b0);
        mem_wdata_o = mem_rdata_i;
        n_d         = n_q + 1'b1;
        state_d     = S_R_M;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      init_pend_q <= 1'b1;
      head_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      init_pend_q <= init_pend_d;
      head_q      <= head_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    need_q     <= need_d;
    addr_q     <= addr_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    sz_q       <= sz_d;
    nxt_q      <= nxt_d;
    pl_q       <= pl_d;
    h_q        <= h_d;
    node_q     <= node_d;
    sum_q      <= sum_d;
    split_q    <= split_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
  end

`ifndef ASSERT_OFF
  // A new result appears only as the sequencer leaves its finishing state.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || out_stall_i) ##1 out_valid_q |-> $past(state_q == S_DONE) ||
    $stable(out_addr_q) && $stable(out_st_q))
    else $error("result appeared outside the finishing state");

  // The heap store is never written while the block waits for an item.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we_o)
    else $error("store write while idle");

  // An item is accepted only after the clearing pass and any setup have finished.
  a_accept_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_A_CHK) || (state_q == S_R_CHK))
    else $error("accepted item did not start a walk");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
`default_nettype none

// First-fit heap allocator whose area headers live in a single-port-read,
// single-port-write store of HEAP_BYTES/4 words. After reset the store is
// swept to zero, one word per cycle, and then set up as one free area if the
// usable size holds a header; no item is taken during that sweep or the setup
// that follows every write to heap_base or heap_size. Each item goes through
// the store at most one header word per cycle: an allocation reads the free
// areas it visits, then writes any split remainder, the previous link, the
// size and the mark; a release checks range and mark, walks the free areas
// ahead of it, then links it in and merges touching neighbors. A finished
// result waits in an output register while the next item is taken.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES  = ffha_pkg::HeapBytesDefault,
  parameter int unsigned ALIGN_BYTES = ffha_pkg::AlignBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic [31:0] release_address_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [31:0] granted_address_o,
  output      logic [1:0]  status_o
);
  import ffha_pkg::*;

  localparam int unsigned StoreWords = HEAP_BYTES / 4;
  localparam int unsigned Aw         = $clog2(StoreWords);
  localparam logic [16:0] CapBytes   = 17'(HEAP_BYTES);

  logic [31:0] base_q, base_d;
  logic [16:0] size_q, size_d;
  logic        cfg_we;
  logic [16:0] capped;
  cfg_t        cfg;

  logic          mem_we;
  logic [Aw-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [Aw-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Register writes; each one restarts the heap.
  always_comb begin
    base_d = base_q;
    size_d = size_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        CfgHeapBase: base_d = cfg_data_i;
        CfgHeapSize: size_d = cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      size_q <= HeapSizeReset;
    end else begin
      base_q <= base_d;
      size_q <= size_d;
    end
  end

  // Usable size: capped at the store and rounded down to a word.
  assign capped        = (size_q > CapBytes) ? CapBytes : size_q;
  assign cfg.base      = base_q;
  assign cfg.eff_size  = {capped[16:2], 2'b00};
  assign cfg.init      = cfg_we;

  ffha_ram #(
    .Width (32),
    .Depth (StoreWords)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffha_ctrl #(
    .HeapBytes  (HEAP_BYTES),
    .AlignBytes (ALIGN_BYTES)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .request_size_i    (request_size_i),
    .release_address_i (release_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_address_o (granted_address_o),
    .status_o          (status_o),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ffha_pkg::*;

  localparam int unsigned StoreWords = 1024;
  localparam int unsigned WalkMax    = StoreWords + 4;
  localparam int unsigned IdleLimit  = 200000;

  typedef struct {
    logic        op;
    logic [15:0] req;
    logic [31:0] addr;
  } heap_req_t;

  typedef struct {
    logic        op;
    logic [31:0] granted;
    logic [1:0]  st;
  } heap_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = CfgHeapBase;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        operation = OpAlloc;
  logic [15:0] request_size = '0;
  logic [31:0] release_address = '0;
  logic        out_stall = 1'b0;
  wire         cfg_ready_o;
  wire         in_stall_o;
  wire         out_valid_o;
  wire  [31:0] granted_address_o;
  wire  [1:0]  status_o;

  first_fit_heap_allocator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation),
    .request_size_i   (request_size),
    .release_address_i(release_address),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .granted_address_o(granted_address_o),
    .status_o         (status_o)
  );

  // Shadow copy of the allocator state.
  logic [31:0] heap_mem [StoreWords];
  logic [31:0] free_head;
  logic [31:0] heap_base_q;
  logic [16:0] heap_size_q;
  logic [31:0] eff_bytes;

  heap_req_t   pending_reqs[$];
  heap_resp_t  awaited_resps[$];
  logic [31:0] live_blocks[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          calm = 1'b0;
  bit          in_took = 1'b0;
  bit          cfg_took = 1'b0;
  heap_req_t   cur_req;

  function automatic logic [31:0] mem_rd(logic [31:0] idx);
    return heap_mem[idx[9:0]];
  endfunction

  function automatic void mem_wr(logic [31:0] idx, logic [31:0] v);
    heap_mem[idx[9:0]] = v;
  endfunction

  function automatic bit area_ok(logic [31:0] off);
    return off != LinkEnd && off[1:0] == 2'b00 && off <= eff_bytes &&
           eff_bytes - off >= HdrBytes;
  endfunction

  function automatic void link_prev(logic [31:0] prev, logic [31:0] v);
    if (prev == LinkEnd) begin
      free_head = v & 32'h1FFFF;
    end else begin
      mem_wr(prev >> 2, v);
    end
  endfunction

  function automatic void setup_heap();
    eff_bytes = (heap_size_q > 17'd4096) ? 32'd4096 : {15'b0, heap_size_q};
    eff_bytes[1:0] = 2'b00;
    if (eff_bytes >= HdrBytes) begin
      free_head = '0;
      mem_wr(0, LinkEnd);
      mem_wr(1, eff_bytes);
    end else begin
      free_head = LinkEnd;
    end
  endfunction

  // First-fit search with split when a usable remainder is left.
  function automatic heap_resp_t alloc_block(logic [15:0] req);
    heap_resp_t  r;
    logic [31:0] need, prev, cur, sz, nxt, nw;
    need = ({16'b0, req} + HdrBytes + 32'd3) & ~32'd3;
    prev = LinkEnd;
    cur = free_head;
    r.op = OpAlloc;
    r.granted = '0;
    r.st = StNoFit;
    for (int n = 0; n < WalkMax && area_ok(cur); n++) begin
      sz = mem_rd((cur >> 2) + 1);
      if (sz >= need) begin
        nxt = mem_rd(cur >> 2);
        if (sz - need < HdrBytes + 32'd4) begin
          link_prev(prev, nxt);
          need = sz;
        end else begin
          nw = cur + need;
          mem_wr(nw >> 2, nxt);
          mem_wr((nw >> 2) + 1, sz - need);
          link_prev(prev, nw);
          mem_wr((cur >> 2) + 1, need);
        end
        mem_wr(cur >> 2, (~need) ^ MarkKey);
        r.granted = heap_base_q + cur + HdrBytes;
        r.st = StDone;
        return r;
      end
      prev = cur;
      cur = mem_rd(cur >> 2);
    end
    return r;
  endfunction

  // Ordered insert of a released area, then merge of touching neighbors.
  function automatic heap_resp_t release_block(logic [31:0] a);
    heap_resp_t  r;
    logic [31:0] off, h, prev, cur, node, nx;
    r.op = OpRelease;
    r.granted = '0;
    r.st = StIgnored;
    if ({1'b0, a} <= {1'b0, heap_base_q} ||
        {1'b0, a} >= {1'b0, heap_base_q} + {1'b0, eff_bytes})
      return r;
    off = a - heap_base_q;
    if (off < HdrBytes || off[1:0] != 2'b00) return r;
    h = off - HdrBytes;
    if (mem_rd(h >> 2) != ((~mem_rd((h >> 2) + 1)) ^ MarkKey)) return r;
    prev = LinkEnd;
    cur = free_head;
    for (int n = 0; n < WalkMax && area_ok(cur) && cur < h; n++) begin
      prev = cur;
      cur = mem_rd(cur >> 2);
    end
    if (!area_ok(cur)) cur = LinkEnd;
    mem_wr(h >> 2, cur);
    link_prev(prev, h);
    node = (prev == LinkEnd) ? h : prev;
    for (int n = 0; n < WalkMax && area_ok(node) && (cur == LinkEnd || node < cur); n++) begin
      nx = mem_rd(node >> 2);
      if (area_ok(nx) && node + mem_rd((node >> 2) + 1) == nx) begin
        mem_wr((node >> 2) + 1, mem_rd((node >> 2) + 1) + mem_rd((nx >> 2) + 1));
        mem_wr(node >> 2, mem_rd(nx >> 2));
      end else begin
        node = nx;
      end
    end
    r.st = StDone;
    return r;
  endfunction

  function automatic void push_alloc(int unsigned sz);
    heap_req_t q;
    q.op = OpAlloc;
    q.req = 16'(sz);
    q.addr = $urandom;
    pending_reqs.push_back(q);
  endfunction

  function automatic void push_release(logic [31:0] a);
    heap_req_t q;
    q.op = OpRelease;
    q.req = 16'($urandom);
    q.addr = a;
    pending_reqs.push_back(q);
  endfunction

  // One random item: mostly small allocations and releases of live blocks.
  function automatic void push_random();
    int unsigned pick, k;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      push_alloc($urandom_range(0, 64));
    end else if (pick < 48) begin
      push_alloc($urandom_range(0, 700));
    end else if (pick < 51) begin
      push_alloc($urandom);
    end else if (pick < 90 && live_blocks.size() > 0) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      push_release(live_blocks[k]);
      live_blocks.delete(k);
    end else if (pick < 94) begin
      push_release($urandom);
    end else begin
      push_release(heap_base_q + $urandom_range(0, eff_bytes + 12));
    end
  endfunction

  // Clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Sampling of all handshakes, prediction and result checks.
  always @(posedge clk_i) begin
    heap_resp_t want;
    in_took <= in_valid && !in_stall_o;
    cfg_took <= cfg_valid && cfg_ready_o;
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
    if (rst_ni && in_valid && !in_stall_o) begin
      if (operation == OpAlloc) begin
        awaited_resps.push_back(alloc_block(request_size));
      end else begin
        awaited_resps.push_back(release_block(release_address));
      end
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      if (awaited_resps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: addr %h status %0d",
                                       granted_address_o, status_o);
      end else begin
        want = awaited_resps.pop_front();
        if (granted_address_o !== want.granted || status_o !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                     want.granted, want.st, granted_address_o, status_o);
        end else if (want.op == OpAlloc && want.st == StDone) begin
          live_blocks.push_back(want.granted);
        end
      end
    end
  end

  // Item driver: a new item is presented only when the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        operation <= cur_req.op;
        request_size <= cur_req.req;
        release_address <= cur_req.addr;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 6) == 0) in_gap <= $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall in random bursts.
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 6) == 0) out_gap <= $urandom_range(1, 4);
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() > 0 || in_valid || awaited_resps.size() > 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk_i);
    while (!cfg_took);
    cfg_valid <= 1'b0;
    if (idx == CfgHeapBase) heap_base_q = data;
    else heap_size_q = data[16:0];
    setup_heap();
    live_blocks.delete();
  endtask

  // Stimulus: a directed opening, then random phases over several heap settings.
  initial begin
    logic [31:0] bases [8];
    logic [31:0] sizes [8];
    for (int i = 0; i < StoreWords; i++) heap_mem[i] = '0;
    heap_base_q = '0;
    heap_size_q = HeapSizeReset;
    setup_heap();
    bases = '{32'h0, 32'hFFFF_FFF0, 32'h1234_5679, 32'h8000_0000,
              32'h0000_0100, 32'hFFFF_FFFC, 32'h0, 32'h4000_0000};
    sizes = '{32'd4096, 32'd4096, 32'd16, 32'h1_0000,
              32'h1_FFFF, 32'd5, 32'd1002, 32'hFFFE_0100};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    push_alloc(0);
    push_alloc(1);
    push_alloc(4);
    push_release(16);
    push_release(28);
    push_release(16);
    push_release(0);
    push_release(4096);
    push_release(10);
    push_release(4);
    push_alloc(16'hFFFF);
    push_alloc(4088);
    push_release(8);
    push_alloc(4088);
    push_alloc(0);
    push_release(8);
    push_alloc(4076);
    push_alloc(0);
    push_release(4092);
    push_release(8);
    push_release(32'hFFFF_FFFF);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(CfgHeapBase, bases[ph]);
        write_reg(CfgHeapSize, sizes[ph]);
      end
      if (ph == 7) calm = 1'b1;
      for (int i = 0; i < 115; i++) begin
        while (pending_reqs.size() > 6) @(negedge clk_i);
        push_random();
        if ($urandom_range(0, 60) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && awaited_resps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
